[rtl/core/atrs_pkg.sv]
// Package for the affine matrix to translation/rotation/scale unit.
// Holds widths, quaternion slot codes and the pipeline carry types.
// No dependencies.
package atrs_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_BITS = 16;
    // sign-extended width for three-term sums of matrix words
    localparam int EXT_W     = WORD_W + 3;
    // clamped square root argument and its shifted radicand
    localparam int ARG_W     = WORD_W + 1;
    localparam int RAD_W     = ARG_W + FRAC_BITS;
    localparam int ROOT_W    = (RAD_W + 1) / 2;
    localparam int SQRT_W    = RAD_W + 2;
    // quotient numerators, dividends and divisors
    localparam int NUM_W     = WORD_W + 1;
    localparam int DIVD_W    = NUM_W + FRAC_BITS;
    localparam int DIVS_W    = ROOT_W + 1;
    localparam int QUO_W     = WORD_W;
    localparam int CMP_W     = DIVS_W + QUO_W;
    // column length
    localparam int SQ_W      = 2 * WORD_W - 1;
    localparam int SUMSQ_W   = 2 * WORD_W;
    localparam int CROOT_W   = WORD_W;
    localparam int CREM_W    = SUMSQ_W + 2;
    localparam int SCALE_W   = WORD_W - 1;

    localparam int N_SLOT    = 4;
    localparam int N_COL     = 3;

    localparam logic [1:0] SLOT_X = 2'd0;
    localparam logic [1:0] SLOT_Y = 2'd1;
    localparam logic [1:0] SLOT_Z = 2'd2;
    localparam logic [1:0] SLOT_W = 2'd3;

    typedef struct packed {
        logic [N_SLOT-1:0][NUM_W-1:0]  num;
        logic [1:0]                    half_slot;
        logic                          half_neg;
        logic [N_COL-1:0][SUMSQ_W-1:0] sumsq;
        logic [N_COL-1:0][WORD_W-1:0]  trans;
    } t_carry;

    typedef struct packed {
        logic [DIVD_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
        logic              neg;
        logic              zero;
        logic              ovf;
    } t_lane;

    typedef struct packed {
        t_lane [N_SLOT-1:0]            lane;
        logic [DIVS_W-1:0]             divisor;
        logic [ROOT_W-2:0]             half;
        logic [1:0]                    half_slot;
        logic                          half_neg;
        logic [N_COL-1:0][CREM_W-1:0]  crem;
        logic [N_COL-1:0][CROOT_W-1:0] croot;
        logic [N_COL-1:0][WORD_W-1:0]  trans;
    } t_dstage;

endpackage

[rtl/core/atrs_if.sv]
// Channel interfaces of the affine matrix decomposition unit.
// Depends on atrs_pkg for the word widths.
interface atrs_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [atrs_pkg::WORD_W-1:0] r0c0, r1c0, r2c0;
    logic signed [atrs_pkg::WORD_W-1:0] r0c1, r1c1, r2c1;
    logic signed [atrs_pkg::WORD_W-1:0] r0c2, r1c2, r2c2;
    logic signed [atrs_pkg::WORD_W-1:0] tx_in, ty_in, tz_in;

    modport source (output valid, r0c0, r1c0, r2c0, r0c1, r1c1, r2c1,
                    r0c2, r1c2, r2c2, tx_in, ty_in, tz_in, input ready);
    modport sink   (input valid, r0c0, r1c0, r2c0, r0c1, r1c1, r2c1,
                    r0c2, r1c2, r2c2, tx_in, ty_in, tz_in, output ready);
endinterface

interface atrs_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [atrs_pkg::WORD_W-1:0] trans_x, trans_y, trans_z;
    logic signed [atrs_pkg::WORD_W-1:0] quat_x, quat_y, quat_z, quat_w;
    logic [atrs_pkg::SCALE_W-1:0]        scale_x, scale_y, scale_z;

    modport source (output valid, trans_x, trans_y, trans_z, quat_x, quat_y,
                    quat_z, quat_w, scale_x, scale_y, scale_z, input ready);
    modport sink   (input valid, trans_x, trans_y, trans_z, quat_x, quat_y,
                    quat_z, quat_w, scale_x, scale_y, scale_z, output ready);
endinterface

[rtl/core/affine_matrix_to_trs_decompose_unit.sv]
// Affine matrix to translation / rotation quaternion / scale decomposition.
// Depends on atrs_pkg and the channel interfaces in atrs_if.sv.
//
// Usage:
//   i_mat carries one item per matrix: the upper 3x3 part (rNcM) and the
//   translation column, signed Q16.16. o_trs returns one item per input:
//   the translation unchanged, the Shoemake quaternion (negated in the
//   positive-trace case) and the length of each column, all saturated.
//   An item is moved when valid and ready are both high.
// Throughput: one item per cycle while the pipeline is not stalled.
// Pipeline: one multiply stage, one set-up stage, 25 square root stages
//   (one root bit each), one divider set-up stage, 32 stages that each
//   retire one quotient bit of the four dividers and one bit of the three
//   column square roots, and the output register.
// Stall: the whole pipeline holds while o_trs.valid is high and
//   o_trs.ready is low; i_mat.ready drops in the same cycle, so nothing is
//   lost or repeated. Bubbles travel as cleared valid bits.
// Reset: i_rst_n (synchronous, active low) clears every valid bit; the
//   unit takes items in the first cycle after reset.
module affine_matrix_to_trs_decompose_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    atrs_in_if.sink           i_mat,
    atrs_out_if.source        o_trs
);

    localparam int WORD_W  = atrs_pkg::WORD_W;
    localparam int EXT_W   = atrs_pkg::EXT_W;
    localparam int ARG_W   = atrs_pkg::ARG_W;
    localparam int ROOT_W  = atrs_pkg::ROOT_W;
    localparam int SQRT_W  = atrs_pkg::SQRT_W;
    localparam int NUM_W   = atrs_pkg::NUM_W;
    localparam int DIVD_W  = atrs_pkg::DIVD_W;
    localparam int DIVS_W  = atrs_pkg::DIVS_W;
    localparam int QUO_W   = atrs_pkg::QUO_W;
    localparam int CMP_W   = atrs_pkg::CMP_W;
    localparam int SQ_W    = atrs_pkg::SQ_W;
    localparam int SUMSQ_W = atrs_pkg::SUMSQ_W;
    localparam int CROOT_W = atrs_pkg::CROOT_W;
    localparam int CREM_W  = atrs_pkg::CREM_W;
    localparam int SCALE_W = atrs_pkg::SCALE_W;
    localparam int N_SLOT  = atrs_pkg::N_SLOT;
    localparam int N_COL   = atrs_pkg::N_COL;

    // matrix element positions in input order (column major)
    localparam int M00 = 0;
    localparam int M10 = 1;
    localparam int M20 = 2;
    localparam int M01 = 3;
    localparam int M11 = 4;
    localparam int M21 = 5;
    localparam int M02 = 6;
    localparam int M12 = 7;
    localparam int M22 = 8;
    localparam int N_M = 9;

    localparam logic signed [EXT_W-1:0] ONE_X = EXT_W'(1) <<< atrs_pkg::FRAC_BITS;
    localparam logic [WORD_W-1:0] SAT_POS = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] SAT_NEG = {1'b1, {(WORD_W-1){1'b0}}};

    logic en;
    logic r_o_v;

    assign en          = !r_o_v || o_trs.ready;
    assign i_mat.ready = en;

    // ---------------------------------------------------------------
    // Stage 1: register the matrix and square every element
    // ---------------------------------------------------------------
    logic signed [WORD_W-1:0]   w_in [N_M];
    logic signed [2*WORD_W-1:0] w_sq [N_M];
    logic signed [WORD_W-1:0]   r_s1_m  [N_M];
    logic [SQ_W-1:0]            r_s1_sq [N_M];
    logic [WORD_W-1:0]          r_s1_t  [N_COL];
    logic                       r_s1_v;

    assign w_in[M00] = i_mat.r0c0;
    assign w_in[M10] = i_mat.r1c0;
    assign w_in[M20] = i_mat.r2c0;
    assign w_in[M01] = i_mat.r0c1;
    assign w_in[M11] = i_mat.r1c1;
    assign w_in[M21] = i_mat.r2c1;
    assign w_in[M02] = i_mat.r0c2;
    assign w_in[M12] = i_mat.r1c2;
    assign w_in[M22] = i_mat.r2c2;

    for (genvar k = 0; k < N_M; k++) begin : g_sq
        assign w_sq[k] = w_in[k] * w_in[k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_mat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < N_M; k++) begin
                r_s1_m[k]  <= w_in[k];
                r_s1_sq[k] <= w_sq[k][SQ_W-1:0];
            end
            r_s1_t[0] <= i_mat.tx_in;
            r_s1_t[1] <= i_mat.ty_in;
            r_s1_t[2] <= i_mat.tz_in;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: branch choice, root argument, numerators, column sums
    // ---------------------------------------------------------------
    logic signed [EXT_W-1:0] x [N_M];
    atrs_pkg::t_carry        n_s2;
    logic [ARG_W-1:0]        n_s2_arg;
    atrs_pkg::t_carry        r_s2;
    logic [ARG_W-1:0]        r_s2_arg;
    logic                    r_s2_v;

    for (genvar k = 0; k < N_M; k++) begin : g_ext
        assign x[k] = EXT_W'(r_s1_m[k]);
    end

    always_comb begin
        logic signed [EXT_W-1:0] tr;
        logic signed [EXT_W-1:0] ax;
        logic [1:0]              axis;

        tr   = x[M00] + x[M11] + x[M22];
        ax   = '0;
        n_s2 = '0;
        for (int c = 0; c < N_COL; c++) begin
            n_s2.trans[c] = r_s1_t[c];
            n_s2.sumsq[c] = SUMSQ_W'(r_s1_sq[3*c]) + SUMSQ_W'(r_s1_sq[3*c+1])
                          + SUMSQ_W'(r_s1_sq[3*c+2]);
        end

        axis = atrs_pkg::SLOT_X;
        if (x[M11] > x[M00]) begin
            axis = atrs_pkg::SLOT_Y;
        end
        if (x[M22] > x[M00] && x[M22] > x[M11]) begin
            axis = atrs_pkg::SLOT_Z;
        end

        if (tr > 0) begin
            n_s2_arg                     = ARG_W'(tr + ONE_X);
            n_s2.num[atrs_pkg::SLOT_X]   = NUM_W'(x[M12] - x[M21]);
            n_s2.num[atrs_pkg::SLOT_Y]   = NUM_W'(x[M20] - x[M02]);
            n_s2.num[atrs_pkg::SLOT_Z]   = NUM_W'(x[M01] - x[M10]);
            n_s2.half_slot               = atrs_pkg::SLOT_W;
            n_s2.half_neg                = 1'b1;
        end else begin
            n_s2.half_slot = axis;
            n_s2.half_neg  = 1'b0;
            unique case (axis)
                atrs_pkg::SLOT_X: begin
                    ax = x[M00] - x[M11] - x[M22] + ONE_X;
                    n_s2.num[atrs_pkg::SLOT_Y] = NUM_W'(x[M01] + x[M10]);
                    n_s2.num[atrs_pkg::SLOT_Z] = NUM_W'(x[M02] + x[M20]);
                    n_s2.num[atrs_pkg::SLOT_W] = NUM_W'(x[M21] - x[M12]);
                end
                atrs_pkg::SLOT_Y: begin
                    ax = x[M11] - x[M22] - x[M00] + ONE_X;
                    n_s2.num[atrs_pkg::SLOT_Z] = NUM_W'(x[M12] + x[M21]);
                    n_s2.num[atrs_pkg::SLOT_X] = NUM_W'(x[M10] + x[M01]);
                    n_s2.num[atrs_pkg::SLOT_W] = NUM_W'(x[M02] - x[M20]);
                end
                atrs_pkg::SLOT_Z: begin
                    ax = x[M22] - x[M00] - x[M11] + ONE_X;
                    n_s2.num[atrs_pkg::SLOT_X] = NUM_W'(x[M20] + x[M02]);
                    n_s2.num[atrs_pkg::SLOT_Y] = NUM_W'(x[M21] + x[M12]);
                    n_s2.num[atrs_pkg::SLOT_W] = NUM_W'(x[M10] - x[M01]);
                end
                default: begin
                    ax = '0;
                end
            endcase
            // clamp a negative argument to zero
            n_s2_arg = (ax > 0) ? ARG_W'(ax) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2     <= n_s2;
            r_s2_arg <= n_s2_arg;
        end
    end

    // ---------------------------------------------------------------
    // Square root of arg << FRAC_BITS, one root bit per stage
    // ---------------------------------------------------------------
    logic [SQRT_W-1:0]  r_ar_rem  [ROOT_W];
    logic [ROOT_W-1:0]  r_ar_root [ROOT_W];
    atrs_pkg::t_carry   r_ar_c    [ROOT_W];
    logic               r_ar_v    [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_ar
        localparam int B = ROOT_W - 1 - s;
        logic [SQRT_W-1:0] w_rem;
        logic [SQRT_W-1:0] w_term;
        logic [ROOT_W-1:0] w_root;
        atrs_pkg::t_carry  w_c;
        logic              w_v;

        if (s == 0) begin : g_first
            assign w_rem  = SQRT_W'({r_s2_arg, {atrs_pkg::FRAC_BITS{1'b0}}});
            assign w_root = '0;
            assign w_c    = r_s2;
            assign w_v    = r_s2_v;
        end else begin : g_next
            assign w_rem  = r_ar_rem[s-1];
            assign w_root = r_ar_root[s-1];
            assign w_c    = r_ar_c[s-1];
            assign w_v    = r_ar_v[s-1];
        end

        assign w_term = (SQRT_W'(w_root) << (B + 1)) | (SQRT_W'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ar_v[s] <= 1'b0;
            end else if (en) begin
                r_ar_v[s] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ar_c[s] <= w_c;
                if (w_rem >= w_term) begin
                    r_ar_rem[s]  <= w_rem - w_term;
                    r_ar_root[s] <= w_root | (ROOT_W'(1) << B);
                end else begin
                    r_ar_rem[s]  <= w_rem;
                    r_ar_root[s] <= w_root;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Divider set-up: magnitudes, divisor, overflow check
    // ---------------------------------------------------------------
    atrs_pkg::t_dstage n_su;
    atrs_pkg::t_dstage r_su;
    logic              r_su_v;

    always_comb begin
        logic [ROOT_W-1:0] root;
        logic [NUM_W-1:0]  num;
        logic [NUM_W-1:0]  mag;
        logic [DIVD_W-1:0] dvd;

        root           = r_ar_root[ROOT_W-1];
        n_su           = '0;
        n_su.divisor   = {root, 1'b0};
        n_su.half      = root[ROOT_W-1:1];
        n_su.half_slot = r_ar_c[ROOT_W-1].half_slot;
        n_su.half_neg  = r_ar_c[ROOT_W-1].half_neg;
        n_su.trans     = r_ar_c[ROOT_W-1].trans;
        for (int c = 0; c < N_COL; c++) begin
            n_su.crem[c]  = CREM_W'(r_ar_c[ROOT_W-1].sumsq[c]);
            n_su.croot[c] = '0;
        end
        for (int l = 0; l < N_SLOT; l++) begin
            num = r_ar_c[ROOT_W-1].num[l];
            mag = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
            dvd = {mag, {atrs_pkg::FRAC_BITS{1'b0}}};
            n_su.lane[l].rem  = dvd;
            n_su.lane[l].quo  = '0;
            n_su.lane[l].neg  = num[NUM_W-1];
            n_su.lane[l].zero = (mag == '0);
            // quotient of 2^QUO_W or more saturates whatever the sign
            n_su.lane[l].ovf  = CMP_W'(dvd) >= (CMP_W'({root, 1'b0}) << QUO_W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_su_v <= 1'b0;
        end else if (en) begin
            r_su_v <= r_ar_v[ROOT_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_su <= n_su;
        end
    end

    // ---------------------------------------------------------------
    // Four dividers and three column roots, one bit per stage
    // ---------------------------------------------------------------
    atrs_pkg::t_dstage r_dv   [QUO_W];
    logic              r_dv_v [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_dv
        localparam int B = QUO_W - 1 - s;
        atrs_pkg::t_dstage w_d;
        atrs_pkg::t_dstage n_d;
        logic              w_v;

        if (s == 0) begin : g_first
            assign w_d = r_su;
            assign w_v = r_su_v;
        end else begin : g_next
            assign w_d = r_dv[s-1];
            assign w_v = r_dv_v[s-1];
        end

        always_comb begin
            logic [CMP_W-1:0]  dsh;
            logic [CREM_W-1:0] term;

            n_d = w_d;
            dsh = CMP_W'(w_d.divisor) << B;
            for (int l = 0; l < N_SLOT; l++) begin
                if (CMP_W'(w_d.lane[l].rem) >= dsh) begin
                    n_d.lane[l].rem    = w_d.lane[l].rem - dsh[DIVD_W-1:0];
                    n_d.lane[l].quo[B] = 1'b1;
                end
            end
            for (int c = 0; c < N_COL; c++) begin
                term = (CREM_W'(w_d.croot[c]) << (B + 1)) | (CREM_W'(1) << (2 * B));
                if (w_d.crem[c] >= term) begin
                    n_d.crem[c]     = w_d.crem[c] - term;
                    n_d.croot[c][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[s] <= 1'b0;
            end else if (en) begin
                r_dv_v[s] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[s] <= n_d;
            end
        end
    end

    // ---------------------------------------------------------------
    // Output register: sign, saturation, half-root slot
    // ---------------------------------------------------------------
    logic [WORD_W-1:0]  n_o_q [N_SLOT];
    logic [SCALE_W-1:0] n_o_s [N_COL];
    logic [WORD_W-1:0]  r_o_q [N_SLOT];
    logic [SCALE_W-1:0] r_o_s [N_COL];
    logic [WORD_W-1:0]  r_o_t [N_COL];

    always_comb begin
        atrs_pkg::t_dstage d;
        logic [WORD_W-1:0] half;

        d    = r_dv[QUO_W-1];
        half = WORD_W'(d.half);
        for (int l = 0; l < N_SLOT; l++) begin
            if (2'(l) == d.half_slot) begin
                n_o_q[l] = d.half_neg ? (WORD_W'(0) - half) : half;
            end else if (d.lane[l].zero) begin
                n_o_q[l] = '0;
            end else if (d.lane[l].ovf) begin
                n_o_q[l] = d.lane[l].neg ? SAT_NEG : SAT_POS;
            end else if (d.lane[l].neg) begin
                n_o_q[l] = d.lane[l].quo[QUO_W-1] ? SAT_NEG
                                                  : (WORD_W'(0) - d.lane[l].quo);
            end else begin
                n_o_q[l] = d.lane[l].quo[QUO_W-1] ? SAT_POS : d.lane[l].quo;
            end
        end
        for (int c = 0; c < N_COL; c++) begin
            n_o_s[c] = d.croot[c][CROOT_W-1] ? {SCALE_W{1'b1}}
                                             : d.croot[c][SCALE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (en) begin
            r_o_v <= r_dv_v[QUO_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < N_SLOT; l++) begin
                r_o_q[l] <= n_o_q[l];
            end
            for (int c = 0; c < N_COL; c++) begin
                r_o_s[c] <= n_o_s[c];
                r_o_t[c] <= r_dv[QUO_W-1].trans[c];
            end
        end
    end

    assign o_trs.valid   = r_o_v;
    assign o_trs.trans_x = r_o_t[0];
    assign o_trs.trans_y = r_o_t[1];
    assign o_trs.trans_z = r_o_t[2];
    assign o_trs.quat_x  = r_o_q[atrs_pkg::SLOT_X];
    assign o_trs.quat_y  = r_o_q[atrs_pkg::SLOT_Y];
    assign o_trs.quat_z  = r_o_q[atrs_pkg::SLOT_Z];
    assign o_trs.quat_w  = r_o_q[atrs_pkg::SLOT_W];
    assign o_trs.scale_x = r_o_s[0];
    assign o_trs.scale_y = r_o_s[1];
    assign o_trs.scale_z = r_o_s[2];

endmodule

[test/atrs_checker.sv]
// Checker for the affine matrix decomposition unit: watches both channels,
// predicts each result from the accepted matrix and compares field by field.
// Depends on atrs_pkg and the channel interfaces in atrs_if.sv.
module atrs_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    atrs_in_if         i_mat,
    atrs_out_if        o_trs,
    output int         o_fail_cnt,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_W    = atrs_pkg::WORD_W;
    localparam int SCALE_W   = atrs_pkg::SCALE_W;
    localparam int FRAC_BITS = atrs_pkg::FRAC_BITS;

    typedef struct {
        logic [WORD_W-1:0]  trans [3];
        logic [WORD_W-1:0]  quat [4];
        logic [SCALE_W-1:0] scale [3];
    } t_trs;

    t_trs trs_q [$];
    int   fail_cnt = 0;

    assign o_fail_cnt = fail_cnt;
    assign o_pending  = trs_q.size();

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] clamp_s32(longint v);
        if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
        if (v < -64'sh80000000) v = -64'sh80000000;
        return v[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] div_by_root(longint d, logic [63:0] root);
        logic [63:0] m;
        longint      q;
        m = (d < 0) ? -d : d;
        if (m == 0) return '0;
        if (root == 0) q = longint'(1) << 40;
        else q = longint'((m << FRAC_BITS) / (root << 1));
        return clamp_s32(d < 0 ? -q : q);
    endfunction

    function automatic logic [63:0] root_from(longint a);
        if (a <= 0) return 0;
        return isqrt(64'(a) << FRAC_BITS);
    endfunction

    function automatic logic [SCALE_W-1:0] column_length(longint a, longint b, longint c);
        logic [63:0] ma, mb, mc, r;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        mc = (c < 0) ? -c : c;
        r  = isqrt(ma * ma + mb * mb + mc * mc);
        return (r > 64'h7FFFFFFF) ? 31'h7FFFFFFF : r[SCALE_W-1:0];
    endfunction

    function automatic t_trs decompose(longint m [3][3], logic [WORD_W-1:0] t [3]);
        t_trs        e;
        longint      trace;
        logic [63:0] root;
        int          i, j, k;
        int          nxt [3];
        nxt = '{1, 2, 0};
        e.trans = t;
        trace = m[0][0] + m[1][1] + m[2][2];
        if (trace > 0) begin
            root = root_from(trace + (longint'(1) << FRAC_BITS));
            e.quat[0] = div_by_root(m[1][2] - m[2][1], root);
            e.quat[1] = div_by_root(m[2][0] - m[0][2], root);
            e.quat[2] = div_by_root(m[0][1] - m[1][0], root);
            e.quat[3] = clamp_s32(-longint'(root >> 1));
        end else begin
            i = 0;
            if (m[1][1] > m[0][0]) i = 1;
            if (m[2][2] > m[0][0] && m[2][2] > m[1][1]) i = 2;
            j = nxt[i];
            k = nxt[j];
            root = root_from(m[i][i] - m[j][j] - m[k][k] + (longint'(1) << FRAC_BITS));
            e.quat[i] = clamp_s32(longint'(root >> 1));
            e.quat[j] = div_by_root(m[i][j] + m[j][i], root);
            e.quat[k] = div_by_root(m[i][k] + m[k][i], root);
            e.quat[3] = div_by_root(m[k][j] - m[j][k], root);
        end
        for (int c = 0; c < 3; c++)
            e.scale[c] = column_length(m[0][c], m[1][c], m[2][c]);
        return e;
    endfunction

    task automatic compare_field(string name, logic [WORD_W-1:0] exp_v,
                                 logic [WORD_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        longint            m [3][3];
        logic [WORD_W-1:0] t [3];
        t_trs              e;
        if (i_rst_n && i_mat.valid && i_mat.ready) begin
            m[0][0] = i_mat.r0c0; m[1][0] = i_mat.r1c0; m[2][0] = i_mat.r2c0;
            m[0][1] = i_mat.r0c1; m[1][1] = i_mat.r1c1; m[2][1] = i_mat.r2c1;
            m[0][2] = i_mat.r0c2; m[1][2] = i_mat.r1c2; m[2][2] = i_mat.r2c2;
            t[0] = i_mat.tx_in; t[1] = i_mat.ty_in; t[2] = i_mat.tz_in;
            trs_q = {trs_q, decompose(m, t)};
        end
        if (i_rst_n && o_trs.valid && o_trs.ready) begin
            if (trs_q.size() == 0) begin
                $error("result with no matrix outstanding");
                fail_cnt++;
            end else begin
                e = trs_q.pop_front();
                compare_field("trans_x", e.trans[0], o_trs.trans_x);
                compare_field("trans_y", e.trans[1], o_trs.trans_y);
                compare_field("trans_z", e.trans[2], o_trs.trans_z);
                compare_field("quat_x", e.quat[0], o_trs.quat_x);
                compare_field("quat_y", e.quat[1], o_trs.quat_y);
                compare_field("quat_z", e.quat[2], o_trs.quat_z);
                compare_field("quat_w", e.quat[3], o_trs.quat_w);
                compare_field("scale_x", {1'b0, e.scale[0]}, {1'b0, o_trs.scale_x});
                compare_field("scale_y", {1'b0, e.scale[1]}, {1'b0, o_trs.scale_y});
                compare_field("scale_z", {1'b0, e.scale[2]}, {1'b0, o_trs.scale_z});
            end
        end
    end
endmodule

[test/tb_top.sv]
// Top of the decomposition unit testbench: clock, reset, matrix stimulus,
// output back-pressure and verdict. Depends on atrs_pkg, atrs_if.sv and
// the checker in atrs_checker.sv.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_W    = atrs_pkg::WORD_W;
    localparam int LATENCY   = 61;
    localparam int IDLE_LIMIT = 5000;
    localparam logic [WORD_W-1:0] ONE  = 32'h0001_0000;
    localparam logic [WORD_W-1:0] SMAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] SMIN = 32'h8000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_cnt;
    int   pending;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    int   quiet_cycles = 0;

    atrs_in_if  mat_ch ();
    atrs_out_if trs_ch ();

    affine_matrix_to_trs_decompose_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (mat_ch.sink),
        .o_trs   (trs_ch.source)
    );

    atrs_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mat      (mat_ch),
        .o_trs      (trs_ch),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        mat_ch.valid = 1'b0;
        {mat_ch.r0c0, mat_ch.r1c0, mat_ch.r2c0} = '0;
        {mat_ch.r0c1, mat_ch.r1c1, mat_ch.r2c1} = '0;
        {mat_ch.r0c2, mat_ch.r1c2, mat_ch.r2c2} = '0;
        {mat_ch.tx_in, mat_ch.ty_in, mat_ch.tz_in} = '0;
        trs_ch.ready = 1'b0;
    end

    // receiver back-pressure
    always @(posedge i_clk)
        trs_ch.ready <= ($urandom_range(99) >= stall_pct);

    // watchdog on cycles with no accepted item
    always @(posedge i_clk) begin
        if ((mat_ch.valid && mat_ch.ready) || (trs_ch.valid && trs_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("affine_matrix_to_trs_decompose_unit regression: fail");
            $finish;
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        unique case ($urandom_range(5))
            0: return $urandom();
            1: return SMAX - $urandom_range(3);
            2: return SMIN + $urandom_range(3);
            3: return $urandom_range(4) * ONE;
            default: return 32'($signed($urandom_range(2 * ONE * 2)) - 2 * ONE);
        endcase
    endfunction

    // hold each item until taken; idle gaps drawn before each item
    task automatic send_matrix(logic [WORD_W-1:0] w [12]);
        while ($urandom_range(99) < send_idle_pct) begin
            mat_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        mat_ch.valid <= 1'b1;
        {mat_ch.r0c0, mat_ch.r1c0, mat_ch.r2c0} <= {w[0], w[1], w[2]};
        {mat_ch.r0c1, mat_ch.r1c1, mat_ch.r2c1} <= {w[3], w[4], w[5]};
        {mat_ch.r0c2, mat_ch.r1c2, mat_ch.r2c2} <= {w[6], w[7], w[8]};
        {mat_ch.tx_in, mat_ch.ty_in, mat_ch.tz_in} <= {w[9], w[10], w[11]};
        @(posedge i_clk);
        while (!mat_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_diag(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
                             logic [WORD_W-1:0] c, logic [WORD_W-1:0] off);
        logic [WORD_W-1:0] w [12];
        foreach (w[n]) w[n] = off + n;
        w[0] = a; w[4] = b; w[8] = c;
        send_matrix(w);
    endtask

    initial begin
        logic [WORD_W-1:0] w [12];
        int                mode;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity, each axis branch, zero matrix, negative diagonal
        send_diag(ONE, ONE, ONE, '0);
        send_diag(ONE, -ONE, -ONE, '0);
        send_diag(-ONE, ONE, -ONE, '0);
        send_diag(-ONE, -ONE, ONE, '0);
        send_diag('0, '0, '0, '0);
        send_diag(-3 * ONE, -3 * ONE, -3 * ONE, 32'h100);
        send_diag(-3 * ONE, -3 * ONE, -3 * ONE, '0);
        send_diag(SMAX, SMAX, SMAX, SMIN);
        send_diag(SMIN, SMIN, SMIN, SMAX);
        send_diag(SMAX, SMIN, SMIN, SMAX);
        send_diag(SMIN, SMAX, SMIN, SMIN);
        send_diag(SMIN, SMIN, SMAX, 32'hFFFF_FFF0);
        foreach (w[n]) w[n] = SMIN;
        send_matrix(w);
        foreach (w[n]) w[n] = SMAX;
        send_matrix(w);
        foreach (w[n]) w[n] = 32'hFFFF_FFFF;
        send_matrix(w);
        foreach (w[n]) w[n] = 32'h1;
        send_matrix(w);

        for (int ph = 0; ph < 4; ph++) begin
            unique case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 77; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 77; end
                default: begin send_idle_pct = 33; stall_pct = 33; end
            endcase
            for (int n = 0; n < 450; n++) begin
                mode = $urandom_range(3);
                foreach (w[x]) w[x] = rand_word();
                // matrices with elements within [-1.0, 1.0] keep the interesting branches busy
                if (mode == 0) begin
                    foreach (w[x]) if (x < 9) w[x] = 32'($signed($urandom_range(2 * ONE)) - ONE);
                end
                send_matrix(w);
            end
        end
        mat_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("affine_matrix_to_trs_decompose_unit regression: pass");
        else
            $display("affine_matrix_to_trs_decompose_unit regression: fail");
        $finish;
    end
endmodule
